FILE: hw/rtl/csm_pkg.sv
package csm_pkg;

	localparam int CSM_NUM_STRIPS   = 4;
	localparam int CSM_CHANNEL_W    = 2;
	localparam int CSM_CH_STRIPS    = 2 ** CSM_CHANNEL_W;
	localparam int CSM_POTS_PER_STRIP = 4;
	localparam int CSM_POT_SEL_W    = 2;
	localparam int CSM_POT_KEY_W    = CSM_CHANNEL_W + CSM_POT_SEL_W;
	localparam int CSM_CC_W         = 7;
	localparam int CSM_ADC_W        = 12;
	localparam int CSM_ENC_W        = 16;
	localparam int CSM_REG_IDX_W    = 3;

	// request kinds
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_POLL   = 1'b1;

	// multiplexer addresses
	localparam logic [2:0] ADDR_FADER = 3'd0;
	localparam logic [2:0] ADDR_POT0  = 3'd1;
	localparam logic [2:0] ADDR_POT3  = 3'd2;
	localparam logic [2:0] ADDR_POT2  = 3'd3;
	localparam logic [2:0] ADDR_POT1  = 3'd4;
	localparam logic [2:0] ADDR_MUTE  = 3'd5;

	// controller values
	localparam logic [CSM_CC_W-1:0] CC_ON   = 7'd127;
	localparam logic [CSM_CC_W-1:0] CC_OFF  = 7'd0;
	localparam logic [CSM_CC_W-1:0] CC_UP   = 7'd1;
	localparam logic [CSM_CC_W-1:0] CC_DOWN = 7'd127;

	// register reset values
	localparam logic [CSM_ADC_W-1:0] RST_MUTE_THRESHOLD = 12'd500;
	localparam logic [CSM_CC_W-1:0]  RST_FADER_BASE     = 7'd10;
	localparam logic [CSM_CC_W-1:0]  RST_POT_BASE       = 7'd20;
	localparam logic [CSM_CC_W-1:0]  RST_MUTE_BASE      = 7'd60;
	localparam logic [CSM_CC_W-1:0]  RST_ENCODER_CC     = 7'd70;
	localparam logic [CSM_CC_W-1:0]  RST_BUTTON_CC      = 7'd71;

	typedef enum logic [CSM_REG_IDX_W-1:0] {
		REG_MUTE_THRESHOLD = 3'd0,
		REG_FADER_CC_BASE  = 3'd1,
		REG_POT_CC_BASE    = 3'd2,
		REG_MUTE_CC_BASE   = 3'd3,
		REG_ENCODER_CC     = 3'd4,
		REG_BUTTON_CC      = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [CSM_ADC_W-1:0] mute_threshold;
		logic [CSM_CC_W-1:0]  fader_cc_base;
		logic [CSM_CC_W-1:0]  pot_cc_base;
		logic [CSM_CC_W-1:0]  mute_cc_base;
		logic [CSM_CC_W-1:0]  encoder_cc;
		logic [CSM_CC_W-1:0]  button_cc;
	} cfg_t;

	typedef struct packed {
		logic                        req_type;
		logic [2:0]                  mux_address;
		logic [CSM_CHANNEL_W-1:0]    channel;
		logic [CSM_ADC_W-1:0]        adc_value;
		logic signed [CSM_ENC_W-1:0] encoder_count;
		logic                        button_pressed;
	} item_t;

	typedef struct packed {
		logic [CSM_CC_W-1:0] cc_number;
		logic [CSM_CC_W-1:0] cc_value;
		logic                last_of_run;
	} msg_t;

	typedef struct packed {
		logic [1:0] count;
		msg_t       m0;
		msg_t       m1;
	} eval_t;

	// pot position within a strip from its multiplexer address
	function automatic logic [CSM_POT_SEL_W-1:0] pot_of_addr(input logic [2:0] addr);
		logic [CSM_POT_SEL_W-1:0] p;
		case (addr)
			ADDR_POT0: p = 2'd0;
			ADDR_POT1: p = 2'd1;
			ADDR_POT2: p = 2'd2;
			default:   p = 2'd3;
		endcase
		return p;
	endfunction

endpackage

FILE: hw/rtl/csm_if.sv
interface csm_item_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [2:0]  mux_address;
	logic [1:0]  channel;
	logic [11:0] adc_value;
	logic signed [15:0] encoder_count;
	logic        button_pressed;

	modport source(output valid, req_type, mux_address, channel, adc_value,
		encoder_count, button_pressed, input ready);
	modport sink(input valid, req_type, mux_address, channel, adc_value,
		encoder_count, button_pressed, output ready);
endinterface

interface csm_msg_if;
	logic       valid;
	logic       ready;
	logic [6:0] cc_number;
	logic [6:0] cc_value;
	logic       last_of_run;

	modport source(output valid, cc_number, cc_value, last_of_run, input ready);
	modport sink(input valid, cc_number, cc_value, last_of_run, output ready);
endinterface

interface csm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [11:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: hw/rtl/control_scan_to_midi_cc.sv
// channel | dir | handshake     | payload
// item    | in  | valid/ready   | req_type, mux_address, channel, adc_value,
//         |     |               | encoder_count, button_pressed
// msg     | out | valid/ready   | cc_number, cc_value, last_of_run
// cfg     | in  | valid/ready   | index (3), data (12); ready is always high
//
// One request a cycle is taken while msg is not stalled. A request waits in
// the input register, where the stored control values are compared and the
// messages built, then moves into a two-slot message buffer. A request that
// yields two messages (encoder step plus button) holds the output until both
// are sent, so the sustained rate is one request a cycle while each makes at
// most one message and msg is not stalled, else set by the single output port.
// Reset clears the control values, mute bits, encoder position and all
// valid flags at once and loads the register defaults. A stall on msg
// holds the buffer, then the input register, then item.ready.
module control_scan_to_midi_cc import csm_pkg::*; #(
	parameter int NUM_STRIPS = CSM_NUM_STRIPS
) (
	input  logic clk,
	input  logic arst_n,
	csm_item_if.sink  item,
	csm_msg_if.source msg,
	csm_cfg_if.sink   cfg
);

	cfg_t  regs;
	eval_t res;
	item_t item_s1;
	logic  s1_valid_q;
	logic  s1_adv;
	logic  buf_free;
	logic  in_take;

	// configuration registers
	csm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// input register: advance when the buffer can take this request's messages
	assign s1_adv     = s1_valid_q && buf_free;
	assign item.ready = !s1_valid_q || s1_adv;
	assign in_take    = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (in_take)
			s1_valid_q <= 1'b1;
		else if (s1_adv)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.req_type       <= item.req_type;
			item_s1.mux_address    <= item.mux_address;
			item_s1.channel        <= item.channel;
			item_s1.adc_value      <= item.adc_value;
			item_s1.encoder_count  <= item.encoder_count;
			item_s1.button_pressed <= item.button_pressed;
		end
	end

	// compare against stored state; state updates as the request leaves
	csm_state #(
		.NUM_STRIPS (NUM_STRIPS)
	) u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.regs   (regs),
		.commit (s1_adv),
		.res    (res)
	);

	// message buffer drains one message a cycle while msg.ready is high
	csm_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.commit   (s1_adv),
		.res      (res),
		.buf_free (buf_free),
		.msg      (msg)
	);

	// a stalled request keeps its payload
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |=> s1_valid_q && $stable(item_s1))
		else $error("input register lost a stalled request");

	// a pair of messages comes out with the first marked as not last
	a_pair_first: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && res.count == 2'd2 |=> msg.valid && !msg.last_of_run)
		else $error("first of a message pair missing or marked last");

	// the second of a pair is ready right after the first is taken
	a_pair_second: assert property (@(posedge clk) disable iff (!arst_n)
		msg.valid && msg.ready && !msg.last_of_run |=> msg.valid)
		else $error("second of a message pair missing");

endmodule

FILE: hw/rtl/csm_cfg.sv
module csm_cfg import csm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	csm_cfg_if.sink cfg,
	output cfg_t regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.mute_threshold <= RST_MUTE_THRESHOLD;
			regs_q.fader_cc_base  <= RST_FADER_BASE;
			regs_q.pot_cc_base    <= RST_POT_BASE;
			regs_q.mute_cc_base   <= RST_MUTE_BASE;
			regs_q.encoder_cc     <= RST_ENCODER_CC;
			regs_q.button_cc      <= RST_BUTTON_CC;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MUTE_THRESHOLD: regs_q.mute_threshold <= cfg.data;
				REG_FADER_CC_BASE:  regs_q.fader_cc_base  <= cfg.data[CSM_CC_W-1:0];
				REG_POT_CC_BASE:    regs_q.pot_cc_base    <= cfg.data[CSM_CC_W-1:0];
				REG_MUTE_CC_BASE:   regs_q.mute_cc_base   <= cfg.data[CSM_CC_W-1:0];
				REG_ENCODER_CC:     regs_q.encoder_cc     <= cfg.data[CSM_CC_W-1:0];
				REG_BUTTON_CC:      regs_q.button_cc      <= cfg.data[CSM_CC_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: hw/rtl/csm_state.sv
module csm_state import csm_pkg::*; #(
	parameter int NUM_STRIPS = CSM_NUM_STRIPS
) (
	input  logic  clk,
	input  logic  arst_n,
	input  item_t item,
	input  cfg_t  regs,
	input  logic  commit,
	output eval_t res
);

	// only strips the channel field can reach get storage
	localparam int STRIPS = (NUM_STRIPS < CSM_CH_STRIPS) ? NUM_STRIPS : CSM_CH_STRIPS;
	localparam int POTS   = STRIPS * CSM_POTS_PER_STRIP;

	logic [CSM_CC_W-1:0]  fader_q [STRIPS];
	logic [CSM_CC_W-1:0]  pot_q   [POTS];
	logic [STRIPS-1:0]    mute_q;
	logic signed [CSM_ENC_W-1:0] enc_last_q;

	logic                     ch_ok, analog;
	logic [CSM_POT_SEL_W-1:0] pot_sel;
	logic [CSM_POT_KEY_W-1:0] pot_key;
	logic [CSM_CC_W-1:0]      fader_cur, pot_cur, sample_v;
	logic [CSM_CC_W-1:0]      fader_num, pot_num, mute_num;
	logic                     mute_was, mute_now;
	logic                     fader_hit, pot_hit, mute_hit, enc_hit, btn_hit, enc_up;
	logic                     is_pot;
	msg_t                     enc_msg, btn_msg;

	assign analog   = (item.req_type == REQ_SAMPLE);
	assign ch_ok    = (32'(item.channel) < 32'(NUM_STRIPS));
	assign pot_sel  = pot_of_addr(item.mux_address);
	assign pot_key  = {item.channel, pot_sel};
	assign sample_v = item.adc_value[CSM_ADC_W-1 -: CSM_CC_W];
	assign mute_now = (item.adc_value < regs.mute_threshold);
	assign is_pot   = (item.mux_address >= ADDR_POT0) && (item.mux_address <= ADDR_POT1);

	assign fader_num = regs.fader_cc_base + CSM_CC_W'(item.channel);
	assign pot_num   = regs.pot_cc_base + CSM_CC_W'(pot_key);
	assign mute_num  = regs.mute_cc_base + CSM_CC_W'(item.channel);

	always_comb begin
		fader_cur = '0;
		mute_was  = 1'b0;
		for (int i = 0; i < STRIPS; i++) begin
			if (item.channel == CSM_CHANNEL_W'(i)) begin
				fader_cur = fader_q[i];
				mute_was  = mute_q[i];
			end
		end
		pot_cur = '0;
		for (int i = 0; i < POTS; i++) begin
			if (pot_key == CSM_POT_KEY_W'(i))
				pot_cur = pot_q[i];
		end
	end

	assign fader_hit = analog && ch_ok && (item.mux_address == ADDR_FADER)
		&& (fader_cur != sample_v);
	assign pot_hit   = analog && ch_ok && is_pot && (pot_cur != sample_v);
	assign mute_hit  = analog && ch_ok && (item.mux_address == ADDR_MUTE)
		&& (mute_now != mute_was);
	assign enc_hit   = !analog && (item.encoder_count != enc_last_q);
	assign enc_up    = (item.encoder_count > enc_last_q);
	assign btn_hit   = !analog && item.button_pressed;

	always_comb begin
		enc_msg = '{cc_number: regs.encoder_cc, cc_value: enc_up ? CC_UP : CC_DOWN,
			last_of_run: !btn_hit};
		btn_msg = '{cc_number: regs.button_cc, cc_value: CC_ON, last_of_run: 1'b1};
		res = '0;
		if (fader_hit) begin
			res.count = 2'd1;
			res.m0    = '{cc_number: fader_num, cc_value: sample_v, last_of_run: 1'b1};
		end else if (pot_hit) begin
			res.count = 2'd1;
			res.m0    = '{cc_number: pot_num, cc_value: sample_v, last_of_run: 1'b1};
		end else if (mute_hit) begin
			res.count = 2'd1;
			res.m0    = '{cc_number: mute_num, cc_value: mute_now ? CC_ON : CC_OFF,
				last_of_run: 1'b1};
		end else if (enc_hit) begin
			res.count = btn_hit ? 2'd2 : 2'd1;
			res.m0    = enc_msg;
			res.m1    = btn_msg;
		end else if (btn_hit) begin
			res.count = 2'd1;
			res.m0    = btn_msg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STRIPS; i++)
				fader_q[i] <= '0;
			for (int i = 0; i < POTS; i++)
				pot_q[i] <= '0;
			mute_q     <= '0;
			enc_last_q <= '0;
		end else if (commit) begin
			for (int i = 0; i < STRIPS; i++) begin
				if (item.channel == CSM_CHANNEL_W'(i)) begin
					if (fader_hit)
						fader_q[i] <= sample_v;
					if (mute_hit)
						mute_q[i] <= mute_now;
				end
			end
			for (int i = 0; i < POTS; i++) begin
				if (pot_hit && pot_key == CSM_POT_KEY_W'(i))
					pot_q[i] <= sample_v;
			end
			if (enc_hit)
				enc_last_q <= item.encoder_count;
		end
	end

endmodule

FILE: hw/rtl/csm_obuf.sv
module csm_obuf import csm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  commit,
	input  eval_t res,
	output logic  buf_free,
	csm_msg_if.source msg
);

	msg_t       slot0_q, slot1_q;
	logic [1:0] cnt_q;
	logic       take;

	assign msg.valid       = (cnt_q != 2'd0);
	assign msg.cc_number   = slot0_q.cc_number;
	assign msg.cc_value    = slot0_q.cc_value;
	assign msg.last_of_run = slot0_q.last_of_run;

	assign take     = msg.valid && msg.ready;
	assign buf_free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else if (commit)
			cnt_q <= res.count;
		else if (take)
			cnt_q <= cnt_q - 2'd1;
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			slot0_q <= res.m0;
			slot1_q <= res.m1;
		end else if (take && cnt_q == 2'd2) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

FILE: dv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import csm_pkg::*;

	// cycles for a request with no message to clear the input register and
	// the message buffer before a register write
	localparam int DRAIN_CYCLES = 8;
	// length of the long receiver hold-off, in cycles
	localparam int HOLD_CYCLES  = 300;
	localparam int NUM_CTL      = CSM_NUM_STRIPS * 5;

	logic clk;
	logic arst_n;

	csm_item_if item_bus();
	csm_msg_if  msg_bus();
	csm_cfg_if  cfg_bus();

	control_scan_to_midi_cc dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.msg    (msg_bus),
		.cfg    (cfg_bus)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Requests waiting for the driver, and messages still owed by the block
	item_t req_queue [$];
	msg_t  cc_due [$];

	// Mirror of the block: register settings and scan state
	cfg_t                        regs;
	logic [CSM_CC_W-1:0]         ctl_vals [NUM_CTL];
	logic [CSM_NUM_STRIPS-1:0]   mute_st;
	logic signed [CSM_ENC_W-1:0] enc_pos;

	// Stimulus side: last encoder count handed out, so polls move in small steps
	logic signed [CSM_ENC_W-1:0] gen_count;

	int  mismatches;
	bit  calm;          // when set, neither side draws random idle gaps
	int  hold_asks;     // raised by the stimulus to ask for a long hold-off
	int  hold_served;
	int  hold_left;

	// Work out the messages one accepted request causes and queue them
	function automatic void forecast_cc(input item_t it);
		msg_t                 outs [2];
		int                   n;
		int                   idx;
		logic [1:0]           p;
		logic [CSM_CC_W-1:0]  num;
		logic [CSM_CC_W-1:0]  v;
		logic                 now;
		n = 0;
		if (it.req_type == REQ_SAMPLE) begin
			// unused addresses and strips beyond the mixer leave everything alone
			if (int'(it.channel) < CSM_NUM_STRIPS && it.mux_address <= ADDR_MUTE) begin
				if (it.mux_address == ADDR_MUTE) begin
					now = it.adc_value < regs.mute_threshold;
					if (now != mute_st[it.channel]) begin
						num = regs.mute_cc_base + {5'b00000, it.channel};
						outs[n] = '{cc_number: num, cc_value: now ? CC_ON : CC_OFF,
							last_of_run: 1'b0};
						n++;
						mute_st[it.channel] = now;
					end
				end else begin
					v = it.adc_value[CSM_ADC_W-1:5];
					if (it.mux_address == ADDR_FADER) begin
						idx = int'(it.channel);
						num = regs.fader_cc_base + {5'b00000, it.channel};
					end else begin
						// the pots are wired to the multiplexer out of order
						case (it.mux_address)
							ADDR_POT0: p = 2'd0;
							ADDR_POT1: p = 2'd1;
							ADDR_POT2: p = 2'd2;
							default:   p = 2'd3;
						endcase
						idx = CSM_NUM_STRIPS + int'(it.channel) * 4 + int'(p);
						// controller numbers wrap modulo 128
						num = regs.pot_cc_base + {3'b000, it.channel, p};
					end
					if (idx < NUM_CTL && ctl_vals[idx] != v) begin
						ctl_vals[idx] = v;
						outs[n] = '{cc_number: num, cc_value: v, last_of_run: 1'b0};
						n++;
					end
				end
			end
		end else begin
			if ($signed(it.encoder_count) != enc_pos) begin
				outs[n] = '{cc_number: regs.encoder_cc,
					cc_value: ($signed(it.encoder_count) > enc_pos) ? CC_UP : CC_DOWN,
					last_of_run: 1'b0};
				n++;
				enc_pos = it.encoder_count;
			end
			if (it.button_pressed) begin
				outs[n] = '{cc_number: regs.button_cc, cc_value: CC_ON, last_of_run: 1'b0};
				n++;
			end
		end
		if (n > 0)
			outs[n-1].last_of_run = 1'b1;
		for (int k = 0; k < n; k++)
			cc_due.push_back(outs[k]);
	endfunction

	// Build a request; fields that this kind ignores get random content
	function automatic item_t mk_req(input logic rt, input logic [2:0] addr,
		input logic [1:0] ch, input logic [11:0] adc, input logic signed [15:0] cnt,
		input logic btn);
		item_t it;
		it.req_type       = rt;
		it.mux_address    = $urandom;
		it.channel        = $urandom;
		it.adc_value      = $urandom;
		it.encoder_count  = $urandom;
		it.button_pressed = $urandom;
		if (rt == REQ_SAMPLE) begin
			it.mux_address = addr;
			it.channel     = ch;
			it.adc_value   = adc;
		end else begin
			it.encoder_count  = cnt;
			it.button_pressed = btn;
		end
		return it;
	endfunction

	// Draw one random request, mostly well-formed scan traffic
	function automatic item_t pick_req();
		int          r;
		int          lvl;
		logic [11:0] adc;
		item_t       it;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			// faders and pots; a narrow value set makes repeats (no message) common
			if ($urandom_range(0, 1) == 0)
				adc = {$urandom_range(0, 3), 5'($urandom)};
			else
				adc = $urandom;
			it = mk_req(REQ_SAMPLE, 3'($urandom_range(0, 4)), $urandom, adc, '0, 1'b0);
		end else if (r < 55) begin
			// mutes: sit around the threshold to flip the pressed state often
			if ($urandom_range(0, 2) != 0) begin
				lvl = int'(regs.mute_threshold) + $urandom_range(0, 5) - 3;
				if (lvl < 0)
					lvl = 0;
				if (lvl > 4095)
					lvl = 4095;
				adc = lvl[11:0];
			end else begin
				adc = $urandom;
			end
			it = mk_req(REQ_SAMPLE, ADDR_MUTE, $urandom, adc, '0, 1'b0);
		end else if (r < 92) begin
			// encoder polls: small steps, now and then a jump or an extreme
			case ($urandom_range(0, 9))
				0:       gen_count = $urandom;
				1:       gen_count = 16'sh7fff;
				2:       gen_count = -16'sh8000;
				default: gen_count = gen_count + 16'($urandom_range(0, 4)) - 16'sd2;
			endcase
			it = mk_req(REQ_POLL, '0, '0, '0, gen_count, $urandom_range(0, 2) == 0);
		end else begin
			// noise: unused addresses, or anything at all
			if ($urandom_range(0, 1) == 0)
				it = mk_req(REQ_SAMPLE, 3'($urandom_range(6, 7)), $urandom, $urandom,
					'0, 1'b0);
			else
				it = item_t'({$urandom, $urandom});
			if (it.req_type == REQ_POLL)
				gen_count = it.encoder_count;
		end
		return it;
	endfunction

	// Write one register and track it in the mirror; only called while idle
	task automatic write_reg(input reg_idx_t idx, input logic [11:0] val);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		case (idx)
			REG_MUTE_THRESHOLD: regs.mute_threshold = val;
			REG_FADER_CC_BASE:  regs.fader_cc_base  = val[6:0];
			REG_POT_CC_BASE:    regs.pot_cc_base    = val[6:0];
			REG_MUTE_CC_BASE:   regs.mute_cc_base   = val[6:0];
			REG_ENCODER_CC:     regs.encoder_cc     = val[6:0];
			REG_BUTTON_CC:      regs.button_cc      = val[6:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input int thr, input int fb, input int pb, input int mb,
		input int ec, input int bc);
		write_reg(REG_MUTE_THRESHOLD, thr[11:0]);
		write_reg(REG_FADER_CC_BASE,  fb[11:0]);
		write_reg(REG_POT_CC_BASE,    pb[11:0]);
		write_reg(REG_MUTE_CC_BASE,   mb[11:0]);
		write_reg(REG_ENCODER_CC,     ec[11:0]);
		write_reg(REG_BUTTON_CC,      bc[11:0]);
	endtask

	task automatic apply_random_setting();
		apply_setting($urandom_range(0, 4095), $urandom_range(0, 124), $urandom_range(0, 112),
			$urandom_range(0, 124), $urandom_range(0, 127), $urandom_range(0, 127));
	endtask

	task automatic queue_random(input int count);
		for (int k = 0; k < count; k++)
			req_queue.push_back(pick_req());
	endtask

	// Hold until every request has gone in and every message has come out,
	// then let requests that make no message drain from the pipeline
	task automatic settle();
		while (req_queue.size() != 0 || item_bus.valid || cc_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Request driver: present the next queued request once the previous one
	// has been taken and its drawn gap has run out
	item_t offered;
	int    src_gap;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_bus.valid          <= 1'b0;
			item_bus.req_type       <= REQ_SAMPLE;
			item_bus.mux_address    <= '0;
			item_bus.channel        <= '0;
			item_bus.adc_value      <= '0;
			item_bus.encoder_count  <= '0;
			item_bus.button_pressed <= 1'b0;
			src_gap = 0;
		end else begin
			if (item_bus.valid && item_bus.ready)
				forecast_cc(offered);
			if (!item_bus.valid || item_bus.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					item_bus.valid <= 1'b0;
				end else if (req_queue.size() > 0) begin
					offered = req_queue.pop_front();
					item_bus.valid          <= 1'b1;
					item_bus.req_type       <= offered.req_type;
					item_bus.mux_address    <= offered.mux_address;
					item_bus.channel        <= offered.channel;
					item_bus.adc_value      <= offered.adc_value;
					item_bus.encoder_count  <= offered.encoder_count;
					item_bus.button_pressed <= offered.button_pressed;
					src_gap = calm ? 0 : $urandom_range(0, 5);
				end else begin
					item_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Long hold-off on the message side, counted here so the driver keeps going
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left   <= 0;
			hold_served <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_asks) begin
			hold_served <= hold_served + 1;
			hold_left   <= HOLD_CYCLES;
		end
	end

	// Message monitor: compare each taken message with the oldest one owed,
	// then draw how long to wait before taking the next
	msg_t due;
	int   rx_wait;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_bus.ready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (msg_bus.valid && msg_bus.ready) begin
				if (cc_due.size() == 0) begin
					$display("%0t: unexpected message cc %0d value %0d last %0b", $time,
						msg_bus.cc_number, msg_bus.cc_value, msg_bus.last_of_run);
					mismatches++;
				end else begin
					due = cc_due.pop_front();
					if (msg_bus.cc_number !== due.cc_number) begin
						$display("%0t: cc_number expected %0d actual %0d", $time,
							due.cc_number, msg_bus.cc_number);
						mismatches++;
					end
					if (msg_bus.cc_value !== due.cc_value) begin
						$display("%0t: cc_value expected %0d actual %0d", $time,
							due.cc_value, msg_bus.cc_value);
						mismatches++;
					end
					if (msg_bus.last_of_run !== due.last_of_run) begin
						$display("%0t: last_of_run expected %0b actual %0b", $time,
							due.last_of_run, msg_bus.last_of_run);
						mismatches++;
					end
				end
				rx_wait = calm ? 0 : $urandom_range(0, 5);
			end
			if (hold_left != 0) begin
				msg_bus.ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				msg_bus.ready <= 1'b0;
			end else begin
				msg_bus.ready <= 1'b1;
			end
		end
	end

	// Stimulus and phase control
	initial begin
		arst_n        = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_MUTE_THRESHOLD;
		cfg_bus.data  = '0;
		mismatches    = 0;
		calm          = 1'b0;
		hold_asks     = 0;
		gen_count     = '0;
		regs = '{mute_threshold: RST_MUTE_THRESHOLD, fader_cc_base: RST_FADER_BASE,
			pot_cc_base: RST_POT_BASE, mute_cc_base: RST_MUTE_BASE,
			encoder_cc: RST_ENCODER_CC, button_cc: RST_BUTTON_CC};
		for (int k = 0; k < NUM_CTL; k++)
			ctl_vals[k] = '0;
		mute_st = '0;
		enc_pos = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests on the reset settings
		req_queue.push_back(mk_req(REQ_SAMPLE, ADDR_FADER, 2'd0, 12'd4095, '0, 1'b0));
		req_queue.push_back(mk_req(REQ_SAMPLE, ADDR_FADER, 2'd0, 12'd4095, '0, 1'b0));
		req_queue.push_back(mk_req(REQ_SAMPLE, ADDR_FADER, 2'd3, 12'd31, '0, 1'b0));
		req_queue.push_back(mk_req(REQ_SAMPLE, ADDR_FADER, 2'd3, 12'd32, '0, 1'b0));
		req_queue.push_back(mk_req(REQ_SAMPLE, ADDR_POT0, 2'd0, 12'd100, '0, 1'b0));
		req_queue.push_back(mk_req(REQ_SAMPLE, ADDR_POT1, 2'd1, 12'd4095, '0, 1'b0));
		req_queue.push_back(mk_req(REQ_SAMPLE, ADDR_POT2, 2'd2, 12'd2048, '0, 1'b0));
		req_queue.push_back(mk_req(REQ_SAMPLE, ADDR_POT3, 2'd3, 12'd4064, '0, 1'b0));
		req_queue.push_back(mk_req(REQ_SAMPLE, ADDR_POT3, 2'd3, 12'd0, '0, 1'b0));
		// mute press, hold, release right at the threshold
		req_queue.push_back(mk_req(REQ_SAMPLE, ADDR_MUTE, 2'd0, 12'd0, '0, 1'b0));
		req_queue.push_back(mk_req(REQ_SAMPLE, ADDR_MUTE, 2'd0, 12'd499, '0, 1'b0));
		req_queue.push_back(mk_req(REQ_SAMPLE, ADDR_MUTE, 2'd0, 12'd500, '0, 1'b0));
		req_queue.push_back(mk_req(REQ_SAMPLE, ADDR_MUTE, 2'd3, 12'd499, '0, 1'b0));
		req_queue.push_back(mk_req(REQ_SAMPLE, ADDR_MUTE, 2'd3, 12'd4095, '0, 1'b0));
		// unused multiplexer addresses
		req_queue.push_back(mk_req(REQ_SAMPLE, 3'd6, 2'd1, 12'd4095, '0, 1'b0));
		req_queue.push_back(mk_req(REQ_SAMPLE, 3'd7, 2'd2, 12'd1234, '0, 1'b0));
		// encoder: extremes, step plus button, button alone, no change
		req_queue.push_back(mk_req(REQ_POLL, '0, '0, '0, 16'sh7fff, 1'b0));
		req_queue.push_back(mk_req(REQ_POLL, '0, '0, '0, -16'sh8000, 1'b1));
		req_queue.push_back(mk_req(REQ_POLL, '0, '0, '0, -16'sh8000, 1'b1));
		req_queue.push_back(mk_req(REQ_POLL, '0, '0, '0, -16'sh8000, 1'b0));
		req_queue.push_back(mk_req(REQ_POLL, '0, '0, '0, 16'sh7fff, 1'b1));
		req_queue.push_back(mk_req(REQ_POLL, '0, '0, '0, 16'sh0000, 1'b0));
		req_queue.push_back(mk_req(REQ_POLL, '0, '0, '0, 16'sh0000, 1'b0));
		settle();

		// Highest settings at which no controller number wraps past 127
		apply_setting(4095, 124, 112, 124, 127, 127);
		queue_random(150);
		settle();

		// All registers at zero: no mute can read as pressed
		apply_setting(0, 0, 0, 0, 0, 0);
		queue_random(150);
		settle();

		// Bases high enough that controller numbers wrap past 127
		apply_setting(2048, 127, 127, 127, 0, 1);
		queue_random(150);
		settle();

		// Long hold-off at the message side while requests keep coming,
		// so the buffer fills and item.ready drops
		apply_random_setting();
		calm = 1'b1;
		@(posedge clk);
		hold_asks <= hold_asks + 1;
		queue_random(150);
		settle();

		// A stretch with no idling on either side
		apply_random_setting();
		queue_random(100);
		settle();
		calm = 1'b0;

		repeat (2) begin
			apply_random_setting();
			queue_random(125);
			settle();
		end

		if (mismatches == 0 && cc_due.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// Watchdog well beyond the slowest correct run
	initial begin
		#2000000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

FILE: control_scan_to_midi_cc.f
hw/rtl/csm_pkg.sv
hw/rtl/csm_if.sv
hw/rtl/csm_cfg.sv
hw/rtl/csm_state.sv
hw/rtl/csm_obuf.sv
hw/rtl/control_scan_to_midi_cc.sv
dv/tb_top.sv
